/* rtl/core/sprite_animation_frame_timer_core_defines.svh */
// ----------------------------------------------------------------------------
// sprite animation frame timer - assertion macros
// shared assertion helpers; the using module provides clk and arst_n
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_FRAME_TIMER_CORE_DEFINES_SVH
`define SPRITE_ANIMATION_FRAME_TIMER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SAFT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds on every cycle out of reset
`define SAFT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

/* rtl/core/saft_pkg.sv */
// ----------------------------------------------------------------------------
// saft_pkg
// types and constants shared by the sprite animation frame timer modules
// ----------------------------------------------------------------------------
package saft_pkg;

	localparam int MAX_FRAMES = 256;

	localparam logic [8:0]  MAX_FRAMES_V   = 9'(MAX_FRAMES);
	localparam logic [31:0] MIN_INTERVAL   = 32'd66;
	localparam logic [31:0] INTERVAL_RESET = 32'd65536;
	localparam logic [31:0] BASE_RESET     = 32'd65536;

	// configuration register indexes
	localparam logic [2:0] CFG_NUM_FRAMES     = 3'd0;
	localparam logic [2:0] CFG_BASE_PERIOD    = 3'd1;
	localparam logic [2:0] CFG_LOOP_PAUSE     = 3'd2;
	localparam logic [2:0] CFG_ANIMATE_ENABLE = 3'd3;
	localparam logic [2:0] CFG_STOP_AT_END    = 3'd4;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SET    = 2'd1,
		MODE_REWIND = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RUN_STOP  = 2'd0,
		RUN_PLAY  = 2'd1,
		RUN_PAUSE = 2'd2
	} run_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_WAIT,
		ST_INTERVAL,
		ST_QUO_WAIT,
		ST_LOOP,
		ST_MOD_WAIT,
		ST_PAUSE_MUL,
		ST_PAUSE_SET,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [31:0]        time_step;
		logic signed [31:0] speed;
		logic signed [15:0] frame_value;
		logic signed [15:0] query_frame;
	} cmd_t;

	typedef struct packed {
		logic [8:0]  num_frames;
		logic [31:0] base_period;
		logic [31:0] loop_pause;
		logic        animate_enable;
		logic        stop_at_end;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] current_frame;
		logic               changed;
		logic               wrapped;
		logic               animating;
		logic               passed;
	} res_t;

endpackage

/* rtl/core/saft_front.sv */
// ----------------------------------------------------------------------------
// saft_front
// accepts items, decodes the mode and queues commands for the sequencer
// ----------------------------------------------------------------------------
module saft_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [31:0]        time_step,
	input  logic signed [31:0] speed,
	input  logic signed [15:0] frame_value,
	input  logic signed [15:0] query_frame,
	output logic               cmd_valid,
	output saft_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);

	saft_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           wr_en;
	logic           rd_en;
	saft_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.time_step   = time_step;
		cmd_in.speed       = speed;
		cmd_in.frame_value = frame_value;
		cmd_in.query_frame = query_frame;
		unique case (mode)
			2'd0:    cmd_in.mode = saft_pkg::MODE_TICK;
			2'd1:    cmd_in.mode = saft_pkg::MODE_SET;
			2'd2:    cmd_in.mode = saft_pkg::MODE_REWIND;
			default: cmd_in.mode = saft_pkg::MODE_NONE;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

/* rtl/core/saft_div.sv */
// ----------------------------------------------------------------------------
// saft_div
// 64 by 32 bit unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module saft_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend_hi,
	input  logic [31:0] dividend_lo,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);

	// dividend_hi must be below divisor so the quotient fits in 32 bits
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] r1;
	logic [32:0] r2;
	logic        ge1;
	logic        ge2;
	logic [31:0] r1n;
	logic [31:0] r2n;

	always_comb begin
		r1  = {rem_q, quo_q[31]};
		ge1 = (r1 >= {1'b0, div_q});
		r1n = ge1 ? 32'(r1 - {1'b0, div_q}) : r1[31:0];
		r2  = {r1n, quo_q[30]};
		ge2 = (r2 >= {1'b0, div_q});
		r2n = ge2 ? 32'(r2 - {1'b0, div_q}) : r2[31:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi;
			quo_q <= dividend_lo;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2n;
			quo_q <= {quo_q[29:0], ge1, ge2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/saft_back.sv */
// ----------------------------------------------------------------------------
// saft_back
// sequencer that carries out commands and holds the animation state
// ----------------------------------------------------------------------------
`include "sprite_animation_frame_timer_core_defines.svh"

module saft_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  saft_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  saft_pkg::cfg_t cfg,
	output logic           res_valid,
	output saft_pkg::res_t res,
	input  logic           res_ready
);

	saft_pkg::state_t   state_q;
	saft_pkg::state_t   state_d;
	saft_pkg::run_t     run_q;
	logic signed [15:0] frame_q;
	logic signed [15:0] prev_q;
	logic [31:0]        acc_q;
	logic [31:0]        interval_q;
	logic               changed_q;
	logic               looped_q;

	saft_pkg::cmd_t     cmd_q;
	logic signed [17:0] f_q;
	logic [8:0]         fc_q;
	logic [63:0]        sq_q;
	logic [40:0]        prod_q;

	logic               div_start;
	logic [31:0]        div_hi;
	logic [31:0]        div_lo;
	logic [31:0]        div_d;
	logic               div_busy;
	logic               div_done;
	logic [31:0]        div_quot;
	logic [31:0]        div_rem;

	logic [8:0]         fc_eff;
	logic [32:0]        sum;
	logic [31:0]        elapsed;
	logic [31:0]        iv;
	logic signed [15:0] frame_cl;
	logic               tick_go;
	logic               advance;
	logic signed [17:0] f_next;
	logic               quo_path;
	logic [17:0]        diff;
	logic [41:0]        pause_p;

	saft_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.dividend_hi (div_hi),
		.dividend_lo (div_lo),
		.divisor     (div_d),
		.busy        (div_busy),
		.done        (div_done),
		.quot        (div_quot),
		.rem         (div_rem)
	);

	always_comb begin
		if (cfg.num_frames == 9'd0) begin
			fc_eff = 9'd1;
		end else if (cfg.num_frames > saft_pkg::MAX_FRAMES_V) begin
			fc_eff = saft_pkg::MAX_FRAMES_V;
		end else begin
			fc_eff = cfg.num_frames;
		end
		sum      = {1'b0, cmd.time_step} + {1'b0, acc_q};
		elapsed  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		iv       = (interval_q != 32'd0) ? interval_q : saft_pkg::MIN_INTERVAL;
		frame_cl = frame_q;
		if (run_q != saft_pkg::RUN_STOP && frame_q >= $signed({7'd0, fc_eff})) begin
			frame_cl = $signed({7'd0, 9'(fc_eff - 9'd1)});
		end
		tick_go  = (run_q != saft_pkg::RUN_STOP) && cfg.animate_enable && (iv <= elapsed);
		advance  = (cmd_q.speed > 32'sd0) || (cfg.base_period == 32'd0);
		f_next   = {{2{frame_q[15]}}, frame_q}
		         + (advance ? $signed({10'd0, div_quot[7:0]}) : 18'sd0);
		// base squared over speed, only when the quotient fits in 32 bits
		quo_path = (cfg.base_period != 32'd0) && (cmd_q.speed > 32'sd0)
		         && (sq_q[63:32] < $unsigned(cmd_q.speed));
		diff     = $unsigned(f_q) - {9'd0, fc_q};
		pause_p  = {10'd0, cfg.loop_pause} - {1'b0, prod_q};
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		div_start = 1'b0;
		div_hi    = 32'd0;
		div_lo    = 32'd0;
		div_d     = 32'd0;
		unique case (state_q)
			saft_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.mode == saft_pkg::MODE_TICK && tick_go) begin
						div_start = 1'b1;
						div_lo    = elapsed;
						div_d     = iv;
						state_d   = saft_pkg::ST_DIV_WAIT;
					end else begin
						state_d = saft_pkg::ST_EMIT;
					end
				end
			end
			saft_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = saft_pkg::ST_INTERVAL;
			end
			saft_pkg::ST_INTERVAL: begin
				if (quo_path) begin
					div_start = 1'b1;
					div_hi    = sq_q[63:32];
					div_lo    = sq_q[31:0];
					div_d     = $unsigned(cmd_q.speed);
					state_d   = saft_pkg::ST_QUO_WAIT;
				end else begin
					state_d = saft_pkg::ST_LOOP;
				end
			end
			saft_pkg::ST_QUO_WAIT: begin
				if (div_done) state_d = saft_pkg::ST_LOOP;
			end
			saft_pkg::ST_LOOP: begin
				if (!looped_q) begin
					state_d = saft_pkg::ST_FINISH;
				end else if (cfg.loop_pause == 32'd0 || run_q == saft_pkg::RUN_PAUSE) begin
					// wrap the frame modulo the count
					div_start = 1'b1;
					div_lo    = {14'd0, $unsigned(f_q)};
					div_d     = {23'd0, fc_q};
					state_d   = saft_pkg::ST_MOD_WAIT;
				end else begin
					state_d = saft_pkg::ST_PAUSE_MUL;
				end
			end
			saft_pkg::ST_MOD_WAIT: begin
				if (div_done) state_d = saft_pkg::ST_FINISH;
			end
			saft_pkg::ST_PAUSE_MUL: state_d = saft_pkg::ST_PAUSE_SET;
			saft_pkg::ST_PAUSE_SET: state_d = saft_pkg::ST_FINISH;
			saft_pkg::ST_FINISH:    state_d = saft_pkg::ST_EMIT;
			saft_pkg::ST_EMIT: begin
				if (res_ready) state_d = saft_pkg::ST_IDLE;
			end
			default: state_d = saft_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == saft_pkg::ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			fc_q  <= fc_eff;
			sq_q  <= cfg.base_period * cfg.base_period;
		end
		if (state_q == saft_pkg::ST_DIV_WAIT && div_done) begin
			f_q <= f_next;
		end
		if (state_q == saft_pkg::ST_MOD_WAIT && div_done) begin
			f_q <= $signed({9'd0, div_rem[8:0]});
		end
		if (state_q == saft_pkg::ST_PAUSE_SET) begin
			f_q <= $signed({9'd0, 9'(fc_q - 9'd1)});
		end
		if (state_q == saft_pkg::ST_PAUSE_MUL) begin
			prod_q <= diff[8:0] * cfg.base_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= saft_pkg::RUN_PLAY;
			frame_q    <= 16'sd0;
			prev_q     <= 16'sd0;
			acc_q      <= 32'd0;
			interval_q <= saft_pkg::INTERVAL_RESET;
			changed_q  <= 1'b0;
			looped_q   <= 1'b0;
		end else begin
			unique case (state_q)
				saft_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.mode)
							saft_pkg::MODE_TICK: begin
								changed_q <= 1'b0;
								looped_q  <= 1'b0;
								if (run_q != saft_pkg::RUN_STOP) begin
									frame_q <= frame_cl;
									if (cfg.animate_enable) acc_q <= elapsed;
								end
							end
							saft_pkg::MODE_SET: frame_q <= cmd.frame_value;
							saft_pkg::MODE_REWIND: begin
								changed_q <= 1'b1;
								prev_q    <= frame_q;
								frame_q   <= 16'sd0;
							end
							default: ;
						endcase
					end
				end
				saft_pkg::ST_DIV_WAIT: begin
					if (div_done) begin
						acc_q     <= div_rem;
						changed_q <= 1'b1;
						prev_q    <= frame_q;
						looped_q  <= advance && (f_next >= $signed({9'd0, fc_q}));
					end
				end
				saft_pkg::ST_INTERVAL: begin
					if (cfg.base_period == 32'd0 || cmd_q.speed == 32'sd0) begin
						interval_q <= (cfg.base_period < saft_pkg::MIN_INTERVAL)
						            ? saft_pkg::MIN_INTERVAL : cfg.base_period;
					end else if (cmd_q.speed < 32'sd0) begin
						interval_q <= saft_pkg::MIN_INTERVAL;
					end else if (!quo_path) begin
						interval_q <= 32'hFFFF_FFFF;
					end
				end
				saft_pkg::ST_QUO_WAIT: begin
					if (div_done) begin
						interval_q <= (div_quot < saft_pkg::MIN_INTERVAL)
						            ? saft_pkg::MIN_INTERVAL : div_quot;
					end
				end
				saft_pkg::ST_LOOP: begin
					if (looped_q && (cfg.loop_pause == 32'd0 || run_q == saft_pkg::RUN_PAUSE)) begin
						run_q <= saft_pkg::RUN_PLAY;
					end
				end
				saft_pkg::ST_PAUSE_SET: begin
					// negative or tiny pause remainder drops to the floor
					if (pause_p[41] || pause_p[40:0] < {9'd0, saft_pkg::MIN_INTERVAL}) begin
						interval_q <= saft_pkg::MIN_INTERVAL;
					end else begin
						interval_q <= pause_p[31:0];
					end
					run_q    <= saft_pkg::RUN_PAUSE;
					looped_q <= 1'b0;
				end
				saft_pkg::ST_FINISH: begin
					if (looped_q && cfg.stop_at_end) begin
						run_q   <= saft_pkg::RUN_STOP;
						frame_q <= $signed({7'd0, 9'(fc_q - 9'd1)});
					end else begin
						frame_q <= f_q[15:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.current_frame = frame_q;
		res.changed       = changed_q;
		res.wrapped       = looped_q;
		res.animating     = (run_q != saft_pkg::RUN_STOP) && cfg.animate_enable;
		res.passed        = changed_q && (looped_q
		                  || (cmd_q.query_frame <= frame_q && prev_q < cmd_q.query_frame));
	end

	assign res_valid = (state_q == saft_pkg::ST_EMIT);

	`SAFT_ASSERT_IMPLIES(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
	`SAFT_ASSERT_ALWAYS(a_interval_floor, interval_q >= saft_pkg::MIN_INTERVAL, "interval below floor")
	`SAFT_ASSERT_IMPLIES(a_wrap_changed, res_valid && res.wrapped, res.changed, "wrap without change")
	`SAFT_ASSERT_IMPLIES(a_pass_changed, res_valid && res.passed, res.changed, "pass without change")

endmodule

/* rtl/core/sprite_animation_frame_timer_core.sv */
// set frame, rewind and idle ticks go from the command queue to the result without a divider run
// a tick that steps the frame runs the radix-4 divider up to three times
// (step count, speed interval, frame wrap)
// one item is processed at a time; up to two more wait in the command queue
// arst_n clears the queues and state; frame 0, running, interval 1.0 s
// ----------------------------------------------------------------------------
// sprite_animation_frame_timer_core
// animation frame sequencer with configuration registers and result register
// ----------------------------------------------------------------------------
module sprite_animation_frame_timer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [31:0]        time_step,
	input  logic signed [31:0] speed,
	input  logic signed [15:0] frame_value,
	input  logic signed [15:0] query_frame,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] current_frame,
	output logic               changed,
	output logic               wrapped,
	output logic               animating,
	output logic               passed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	saft_pkg::cfg_t cfg_q;
	saft_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	saft_pkg::res_t res;
	logic           res_valid;
	logic           res_ready;
	saft_pkg::res_t out_q;
	logic           out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_frames     <= 9'd1;
			cfg_q.base_period    <= saft_pkg::BASE_RESET;
			cfg_q.loop_pause     <= 32'd0;
			cfg_q.animate_enable <= 1'b1;
			cfg_q.stop_at_end    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				saft_pkg::CFG_NUM_FRAMES:     cfg_q.num_frames     <= cfg_data[8:0];
				saft_pkg::CFG_BASE_PERIOD:    cfg_q.base_period    <= cfg_data;
				saft_pkg::CFG_LOOP_PAUSE:     cfg_q.loop_pause     <= cfg_data;
				saft_pkg::CFG_ANIMATE_ENABLE: cfg_q.animate_enable <= cfg_data[0];
				saft_pkg::CFG_STOP_AT_END:    cfg_q.stop_at_end    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	saft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.time_step   (time_step),
		.speed       (speed),
		.frame_value (frame_value),
		.query_frame (query_frame),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	saft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// result register; refills on the same cycle it is popped
	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign empty         = !out_valid_q;
	assign current_frame = out_q.current_frame;
	assign changed       = out_q.changed;
	assign wrapped       = out_q.wrapped;
	assign animating     = out_q.animating;
	assign passed        = out_q.passed;

endmodule
